// ===== sv/phslp_pkg.sv =====
// Shared types, sizes and codes for the pointer hash set.
package phslp_pkg;

  // Table geometry.
  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int KEY_W       = 64;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Fibonacci hash multiplier and the slices of it that the home slot needs.
  localparam logic [KEY_W-1:0]  HASH_MULT   = 64'h9E3779B97F4A7C15;
  localparam logic [31:0]       HASH_C_LO   = HASH_MULT[31:0];
  localparam logic [SLOT_W-1:0] HASH_C_HI   = HASH_MULT[32 +: SLOT_W];
  localparam logic [SLOT_W-1:0] HASH_C_LO_N = HASH_MULT[SLOT_W-1:0];
  localparam int                KEY_SHIFT   = 4;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_NOT_FOUND = 2'd1;
  localparam status_t STAT_FULL      = 2'd2;
  localparam status_t STAT_ZERO_KEY  = 2'd3;

  // Slot tag codes.
  typedef logic [1:0] tag_t;
  localparam tag_t TAG_EMPTY = 2'd0;
  localparam tag_t TAG_LIVE  = 2'd1;
  localparam tag_t TAG_DEAD  = 2'd2;

  // One classified operation as it travels from the front to the back.
  typedef struct packed {
    logic              op;
    logic              zero_key;
    logic [SLOT_W-1:0] home;
    logic [KEY_W-1:0]  key;
  } item_t;

  // Status that the back reports to the top level.
  typedef struct packed {
    logic clearing;
    logic probing;
  } back_stat_t;

endpackage

// ===== sv/phslp_front.sv =====
// Front end: accepts operations, flags zero keys and computes the home slot.
module phslp_front
  import phslp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             in_op,
  input  logic [KEY_W-1:0] in_key,
  input  logic             q_full,
  output logic             s1_busy,
  output logic             push,
  output item_t            push_item
);

  logic [KEY_W-1:0]  key_sh;
  logic [63:0]       prod_lo;
  logic [SLOT_W-1:0] cross_a;
  logic [SLOT_W-1:0] cross_b;

  logic              s1_valid_r, s1_valid_nxt;
  logic              op_r;
  logic              zero_r;
  logic [KEY_W-1:0]  key_r;
  logic [SLOT_W-1:0] prod_hi_r;
  logic [SLOT_W-1:0] cross_r;

  // Partial products of (key >> 4) * multiplier; only product bits from 32 upward matter.
  always_comb begin
    key_sh  = in_key >> KEY_SHIFT;
    prod_lo = 64'(key_sh[31:0]) * 64'(HASH_C_LO);
    cross_a = SLOT_W'(key_sh[SLOT_W-1:0] * HASH_C_HI);
    cross_b = SLOT_W'(key_sh[32 +: SLOT_W] * HASH_C_LO_N);
  end

  // The stage holds one operation until the queue has room for it.
  assign push    = s1_valid_r && !q_full;
  assign s1_busy = s1_valid_r && q_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      key_r     <= in_key;
      zero_r    <= (in_key == '0);
      prod_hi_r <= prod_lo[32 +: SLOT_W];
      cross_r   <= SLOT_W'(cross_a + cross_b);
    end
  end

  // Final add of the partial products gives the home slot.
  always_comb begin
    push_item.op       = op_r;
    push_item.zero_key = zero_r;
    push_item.key      = key_r;
    push_item.home     = SLOT_W'(prod_hi_r + cross_r);
  end

endmodule

// ===== sv/phslp_queue.sv =====
// Short queue of classified operations between the front and the back.
module phslp_queue
  import phslp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head_item,
  output logic  q_full,
  output logic  q_empty
);

  item_t             store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign q_full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty   = (count_r == '0);
  assign head_item = store_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = (QPTR_W+1)'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = (QPTR_W+1)'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/phslp_back.sv =====
// Back end: clears the tag store, probes the slot table and issues results.
module phslp_back
  import phslp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  item_t              head_item,
  input  logic               q_empty,
  output logic               pop,
  output back_stat_t         stat,
  output logic               out_valid,
  output status_t            out_status,
  output logic [SLOT_W-1:0]  out_slot_index,
  output logic [CNT_W-1:0]   out_entry_count,
  output logic [CNT_W-1:0]   out_tombstone_count
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;

  localparam logic [CNT_W+2:0] FULL_LIMIT = (CNT_W+3)'(TABLE_SLOTS * 3);

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] probe_cnt_r, probe_cnt_nxt;
  item_t             cur_r, cur_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0]  dead_r, dead_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]  out_live_r;
  logic [CNT_W-1:0]  out_dead_r;

  // Slot stores: the tag store is swept clear after reset, the address store is not.
  tag_t              tag_mem [TABLE_SLOTS];
  logic [KEY_W-1:0]  addr_mem [TABLE_SLOTS];
  tag_t              rd_tag_r;
  logic [KEY_W-1:0]  rd_addr_r;
  logic [SLOT_W-1:0] rd_idx;
  logic              tag_we;
  logic [SLOT_W-1:0] tag_wa;
  tag_t              tag_wd;
  logic              addr_we;

  logic [CNT_W:0]    needed;
  logic              load_full;
  logic              last_probe;

  always_comb begin
    needed     = (CNT_W+1)'({1'b0, live_r} + {1'b0, dead_r} + 1'b1);
    load_full  = ({needed, 2'b00} >= FULL_LIMIT);
    last_probe = &probe_cnt_r;
  end

  // Sequencer for the clearing sweep and the probe walk.
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    idx_nxt        = idx_r;
    probe_cnt_nxt  = probe_cnt_r;
    cur_nxt        = cur_r;
    live_nxt       = live_r;
    dead_nxt       = dead_r;
    pop            = 1'b0;
    rd_idx         = SLOT_W'(idx_r + 1'b1);
    tag_we         = 1'b0;
    tag_wa         = idx_r;
    tag_wd         = TAG_LIVE;
    addr_we        = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_slot_nxt   = '0;

    unique case (state_r)
      S_CLEAR: begin
        tag_we      = 1'b1;
        tag_wa      = clr_cnt_r;
        tag_wd      = TAG_EMPTY;
        clr_cnt_nxt = SLOT_W'(clr_cnt_r + 1'b1);
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        rd_idx = head_item.home;
        if (!q_empty) begin
          pop     = 1'b1;
          cur_nxt = head_item;
          if (head_item.zero_key) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_ZERO_KEY;
          end else if (head_item.op == OP_INSERT && load_full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FULL;
          end else if (head_item.op == OP_REMOVE && live_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_NOT_FOUND;
          end else begin
            idx_nxt       = head_item.home;
            probe_cnt_nxt = '0;
            state_nxt     = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (cur_r.op == OP_INSERT) begin
          if (rd_tag_r != TAG_LIVE) begin
            // Take the empty slot or reuse the tombstone.
            tag_we   = 1'b1;
            tag_wd   = TAG_LIVE;
            addr_we  = 1'b1;
            live_nxt = CNT_W'(live_r + 1'b1);
            if (rd_tag_r == TAG_DEAD && dead_r != '0) begin
              dead_nxt = CNT_W'(dead_r - 1'b1);
            end
            out_valid_nxt = 1'b1;
            out_slot_nxt  = idx_r;
            state_nxt     = S_IDLE;
          end else if (last_probe) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FULL;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt       = SLOT_W'(idx_r + 1'b1);
            probe_cnt_nxt = SLOT_W'(probe_cnt_r + 1'b1);
          end
        end else begin
          if (rd_tag_r == TAG_EMPTY) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_NOT_FOUND;
            state_nxt      = S_IDLE;
          end else if (rd_tag_r == TAG_LIVE && rd_addr_r == cur_r.key) begin
            // Matching live slot becomes a tombstone.
            tag_we        = 1'b1;
            tag_wd        = TAG_DEAD;
            live_nxt      = CNT_W'(live_r - 1'b1);
            dead_nxt      = CNT_W'(dead_r + 1'b1);
            out_valid_nxt = 1'b1;
            out_slot_nxt  = idx_r;
            state_nxt     = S_IDLE;
          end else if (last_probe) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_NOT_FOUND;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt       = SLOT_W'(idx_r + 1'b1);
            probe_cnt_nxt = SLOT_W'(probe_cnt_r + 1'b1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      live_r      <= '0;
      dead_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      live_r      <= live_nxt;
      dead_r      <= dead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the walk and the result.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    cur_r        <= cur_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_live_r   <= live_nxt;
    out_dead_r   <= dead_nxt;
  end

  // Tag store: one write port, one registered read.
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    rd_tag_r <= tag_mem[rd_idx];
  end

  // Address store: one write port, one registered read.
  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[idx_r] <= cur_r.key;
    end
    rd_addr_r <= addr_mem[rd_idx];
  end

  assign stat.clearing       = (state_r == S_CLEAR);
  assign stat.probing        = (state_r == S_PROBE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_slot_index      = out_slot_r;
  assign out_entry_count     = out_live_r;
  assign out_tombstone_count = out_dead_r;

  // Live entries plus tombstones never exceed the table.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, live_r} + {1'b0, dead_r}) <= (CNT_W+1)'(TABLE_SLOTS))
    else $error("live plus tombstone count exceeds table size");

  // Nothing leaves the queue while the tag store is being cleared.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !pop)
    else $error("operation taken during clearing sweep");

  // A successful operation changes the live count by exactly one.
  a_ok_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && out_status_nxt == STAT_OK) |->
      (live_nxt == CNT_W'(live_r + 1'b1) || live_nxt == CNT_W'(live_r - 1'b1)))
    else $error("successful operation left live count unchanged");

  // A failed operation leaves both counts alone.
  a_fail_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && out_status_nxt != STAT_OK) |=>
      ($stable(live_r) && $stable(dead_r)))
    else $error("failed operation changed the counts");

endmodule

// ===== sv/pointer_hash_set_linear_probe.sv =====
// Top level of the pointer hash set with linear probing and tombstones.
//
// Fixed-capacity set of nonzero 64-bit object addresses in a table of 1024 slots.
// After reset the block sweeps its tag store clear, one slot per cycle, through all
// 1024 slots; busy stays high during that sweep. An operation is transferred when start
// is high and busy is low. The front stage registers the hash partial products and
// hands the operation to a two-entry queue; the back sequencer pops it, checks the
// load and count limits, and walks the table one slot per cycle, with one read of
// the tag and address stores for each slot. One result per operation appears on the
// out_ ports for exactly one cycle, marked by out_valid, and is transferred at the
// end of that cycle: the receiver cannot stall it. An operation that needs no probe
// (zero key, full table, remove from an empty set) gets its result without a table
// walk; one that probes gets it when the walk from its home slot ends. Busy drops
// again while the queue has room, so operations can be handed in back to back.
module pointer_hash_set_linear_probe
  import phslp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [KEY_W-1:0]   in_key,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [SLOT_W-1:0]  out_slot_index,
  output logic [CNT_W-1:0]   out_entry_count,
  output logic [CNT_W-1:0]   out_tombstone_count
);

  logic       accept;
  logic       s1_busy;
  logic       push;
  item_t      push_item;
  logic       pop;
  item_t      head_item;
  logic       q_full;
  logic       q_empty;
  back_stat_t stat;

  // Input transfers are held off during the clearing sweep or when the front is stuck.
  assign busy   = s1_busy || stat.clearing;
  assign accept = start && !busy;

  phslp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_op     (in_op),
    .in_key    (in_key),
    .q_full    (q_full),
    .s1_busy   (s1_busy),
    .push      (push),
    .push_item (push_item)
  );

  phslp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_full    (q_full),
    .q_empty   (q_empty)
  );

  phslp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_item           (head_item),
    .q_empty             (q_empty),
    .pop                 (pop),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_entry_count     (out_entry_count),
    .out_tombstone_count (out_tombstone_count)
  );

endmodule

// ===== test/pointer_hash_set_linear_probe_test.sv =====
// Testbench for the pointer hash set: a slot-table scoreboard plus directed and random traffic.
`timescale 1ns / 1ps

module pointer_hash_set_linear_probe_test
  import phslp_pkg::*;
;

  localparam int CYCLE_LIMIT = 2500000;

  // One result as the block reports it.
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  live;
    logic [CNT_W-1:0]  dead;
  } set_result_t;

  // Mirror of the slot table that predicts each result and checks it on arrival.
  class slot_table_board;
    tag_t             slot_tags[TABLE_SLOTS];
    logic [KEY_W-1:0] slot_keys[TABLE_SLOTS];
    int unsigned      live_cnt;
    int unsigned      dead_cnt;
    set_result_t      pending_results[$];
    int unsigned      mismatches;

    function new();
      foreach (slot_tags[i]) slot_tags[i] = TAG_EMPTY;
      live_cnt   = 0;
      dead_cnt   = 0;
      mismatches = 0;
    endfunction

    // Fibonacci hash: bits 32 and up of the shifted key times the multiplier.
    function logic [SLOT_W-1:0] home_of(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] prod;
      prod = (key >> KEY_SHIFT) * HASH_MULT;
      return prod[32 +: SLOT_W];
    endfunction

    // Applies one operation to the mirrored table and returns its result.
    function set_result_t apply_op(logic op, logic [KEY_W-1:0] key);
      set_result_t       res;
      logic [SLOT_W-1:0] idx;
      int                n;
      res.status = STAT_OK;
      res.slot   = '0;
      if (key == '0) begin
        res.status = STAT_ZERO_KEY;
      end else if (op == OP_INSERT) begin
        if ((live_cnt + dead_cnt + 1) * 4 >= TABLE_SLOTS * 3) begin
          res.status = STAT_FULL;
        end else begin
          // Walk past live slots; the first empty or tombstone slot takes the key.
          idx = home_of(key);
          n   = 0;
          while (n < TABLE_SLOTS && slot_tags[idx] == TAG_LIVE) begin
            idx = idx + 1'b1;
            n++;
          end
          if (n == TABLE_SLOTS) begin
            res.status = STAT_FULL;
          end else begin
            if (slot_tags[idx] == TAG_DEAD && dead_cnt > 0) dead_cnt--;
            slot_tags[idx] = TAG_LIVE;
            slot_keys[idx] = key;
            live_cnt++;
            res.slot = idx;
          end
        end
      end else begin
        // Remove walks until an empty slot and buries the first live match.
        res.status = STAT_NOT_FOUND;
        if (live_cnt != 0) begin
          idx = home_of(key);
          for (n = 0; n < TABLE_SLOTS; n++) begin
            if (slot_tags[idx] == TAG_EMPTY) break;
            if (slot_tags[idx] == TAG_LIVE && slot_keys[idx] == key) begin
              slot_tags[idx] = TAG_DEAD;
              live_cnt--;
              dead_cnt++;
              res.status = STAT_OK;
              res.slot   = idx;
              break;
            end
            idx = idx + 1'b1;
          end
        end
      end
      res.live = CNT_W'(live_cnt);
      res.dead = CNT_W'(dead_cnt);
      return res;
    endfunction

    // Called for every operation transfer, in transfer order.
    function void note_transfer(logic op, logic [KEY_W-1:0] key);
      pending_results.push_back(apply_op(op, key));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0d ns  mismatch: %s", $time, what);
    endtask

    // Compares one result transfer with the oldest expected result.
    task check_result(set_result_t got);
      set_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d slot=%0d live=%0d dead=%0d",
                                  got.status, got.slot, got.live, got.dead));
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.slot != want.slot ||
            got.live != want.live || got.dead != want.dead) begin
          report_mismatch($sformatf(
            "status %0d/%0d slot %0d/%0d live %0d/%0d dead %0d/%0d (got/expected)",
            got.status, want.status, got.slot, want.slot,
            got.live, want.live, got.dead, want.dead));
        end
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_op = OP_INSERT;
  logic [KEY_W-1:0]   in_key = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [SLOT_W-1:0]  out_slot_index;
  logic [CNT_W-1:0]   out_entry_count;
  logic [CNT_W-1:0]   out_tombstone_count;

  slot_table_board    board;
  logic [KEY_W-1:0]   key_pool[$];
  int unsigned        cycle_count = 0;

  pointer_hash_set_linear_probe dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_key              (in_key),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_entry_count     (out_entry_count),
    .out_tombstone_count (out_tombstone_count)
  );

  // Free-running clock, 4 ns period.
  initial begin
    forever #2 clk = ~clk;
  end

  // Run guard: the sweep after reset plus a full-table walk and the longest
  // idle gap for every operation still fits several times inside this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL pointer_hash_set_linear_probe");
      $finish;
    end
  end

  // Every strobed result is a transfer; check it against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_result('{status: out_status, slot: out_slot_index,
                           live: out_entry_count, dead: out_tombstone_count});
    end
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Offers one operation, waits for its transfer, then idles a random while.
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key, input int idle_pct);
    int gap;
    start  <= 1'b1;
    in_op  <= op;
    in_key <= key;
    do @(posedge clk); while (busy);
    board.note_transfer(op, key);
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (board.pending_results.size() != 0);
  endtask

  // One random operation: mostly inserts and removes of keys that the set holds
  // or that share a home slot with them, plus misses, duplicates and zero keys.
  task automatic send_random(input int idle_pct);
    int               pick;
    int               at;
    logic             op;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    op   = OP_INSERT;
    key  = random_key();
    at   = (key_pool.size() == 0) ? 0 : $urandom_range(0, key_pool.size() - 1);
    if (key_pool.size() == 0 || pick < 30) begin
      key_pool.push_back(key);
    end else if (pick < 45) begin
      // Same upper bits, new low nibble: same home slot, so the cluster grows.
      key = {key_pool[at][KEY_W-1:4], 4'($urandom)};
      key_pool.push_back(key);
    end else if (pick < 70) begin
      op  = OP_REMOVE;
      key = key_pool[at];
      key_pool.delete(at);
    end else if (pick < 80) begin
      op = OP_REMOVE;
    end else if (pick < 88) begin
      key = key_pool[at];
      key_pool.push_back(key);
    end else if (pick < 93) begin
      op  = 1'($urandom);
      key = '0;
    end else begin
      key = KEY_W'($urandom_range(1, 4095));
      key_pool.push_back(key);
    end
    send_item(op, key, idle_pct);
  endtask

  initial begin
    logic [KEY_W-1:0] wrap_key;
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Find a key whose home is the last slot so that a walk wraps to slot zero.
    wrap_key = 64'h10;
    while (board.home_of(wrap_key) != SLOT_W'(TABLE_SLOTS - 1)) wrap_key += 64'h10;

    // Directed: empty-set remove, zero keys, key extremes, wrap, duplicates,
    // collisions and tombstone reuse.
    send_item(OP_REMOVE, 64'h0000_0000_1234_5670, 26);
    send_item(OP_INSERT, 64'h0, 26);
    send_item(OP_REMOVE, 64'h0, 26);
    send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 26);
    send_item(OP_INSERT, 64'h1, 26);
    send_item(OP_INSERT, 64'h8000_0000_0000_0000, 26);
    send_item(OP_INSERT, wrap_key, 26);
    send_item(OP_INSERT, wrap_key + 64'h1, 26);
    send_item(OP_INSERT, 64'hDEAD_BEEF_0000_1000, 26);
    send_item(OP_INSERT, 64'hDEAD_BEEF_0000_1000, 26);
    send_item(OP_REMOVE, 64'hDEAD_BEEF_0000_1000, 26);
    send_item(OP_REMOVE, 64'hDEAD_BEEF_0000_1000, 26);
    send_item(OP_REMOVE, 64'hDEAD_BEEF_0000_1000, 26);
    send_item(OP_INSERT, 64'hDEAD_BEEF_0000_1000, 26);
    send_item(OP_INSERT, 64'hA5A5_0000_0000_0020, 26);
    send_item(OP_INSERT, 64'hA5A5_0000_0000_0021, 26);
    send_item(OP_INSERT, 64'hA5A5_0000_0000_0022, 26);
    send_item(OP_REMOVE, 64'hA5A5_0000_0000_0021, 26);
    send_item(OP_REMOVE, 64'hA5A5_0000_0000_0023, 26);
    send_item(OP_INSERT, 64'hA5A5_0000_0000_0024, 26);
    send_item(OP_REMOVE, wrap_key, 26);
    send_item(OP_REMOVE, wrap_key + 64'h1, 26);
    send_item(OP_INSERT, 64'h5555_5555_5555_5555, 26);
    send_item(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 26);
    send_item(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 26);
    wait_drained();

    // Random traffic with light sender idling, then heavy, then none.
    repeat (140) send_random(26);
    wait_drained();
    repeat (140) send_random(64);
    wait_drained();
    repeat (140) send_random(0);
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (64) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("PASS pointer_hash_set_linear_probe");
    end else begin
      $display("FAIL pointer_hash_set_linear_probe");
    end
    $finish;
  end

endmodule

// ===== pointer_hash_set_linear_probe.f =====
sv/phslp_pkg.sv
sv/phslp_front.sv
sv/phslp_queue.sv
sv/phslp_back.sv
sv/pointer_hash_set_linear_probe.sv
test/pointer_hash_set_linear_probe_test.sv
